>>> hw/rtl/pisc_pkg.sv
// Shared widths, reset values, types and the saturation helper of the PID block.
package pisc_pkg;

    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 31;
    localparam int SEP_W      = 15;
    localparam int DRV_W      = 32;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int FRAC_SHIFT = 8;
    localparam int TERM_W     = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = TERM_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] RST_GAIN_P  = GAIN_W'(2013266);
    localparam logic [GAIN_W-1:0] RST_GAIN_I  = GAIN_W'(1174);
    localparam logic [GAIN_W-1:0] RST_GAIN_D  = '0;
    localparam logic [LIM_W-1:0]  RST_OUT_LIM = LIM_W'(2621440);
    localparam logic [LIM_W-1:0]  RST_INT_LIM = LIM_W'(1310720);
    localparam logic [SEP_W-1:0]  RST_SEP_LIM = SEP_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_OUT_LIM = 3'd3,
        CFG_INT_LIM = 3'd4,
        CFG_SEP_LIM = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  out_lim;
        logic [LIM_W-1:0]  int_lim;
        logic [SEP_W-1:0]  sep_lim;
    } t_cfg;

    // Per-stage load enables and the strobes that mark a real transaction.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic take1;
        logic take3;
    } t_pipe_ctl;

    // Symmetric saturation of a wide signed value to +/- lim.
    function automatic logic signed [DRV_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        pos = signed'({{(SUM_W-LIM_W){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            return pos[DRV_W-1:0];
        end else if (v < neg) begin
            return neg[DRV_W-1:0];
        end else begin
            return v[DRV_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/pid_integral_separation_clamp.sv
// Top level of the positional PID controller with integral separation and clamps.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_error_sample (16-bit signed)
//   output    out        o_valid / i_stall    o_drive_value  (32-bit signed Q16.16)
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A transaction is accepted on each rising edge with valid high and stall low.
// The result passes through the input, product, integrator and output registers
// before it is valid, and one transaction can enter in every cycle while the
// output is not stalled; the loop that sets this rate is the integrator add and
// clamp in stage three.
// Reset is synchronous and active low: it empties the pipeline, zeroes the
// integrator and the previous error, and restores the register defaults.
// A stall on the output only backs up stages that hold data, so empty stages
// keep taking new transactions while a finished result waits.
module pid_integral_separation_clamp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [pisc_pkg::ERR_W-1:0]   i_error_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pisc_pkg::DRV_W-1:0]   o_drive_value,
    input  logic                                i_cfg_we,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pisc_pkg::*;

    t_cfg      cfg;
    t_pipe_ctl ctl;

    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_d;
    logic                     sep_ok;

    // Stage valid bits: stage one is the input register, two the products,
    // three the integrator and partial sum, four the output register.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        ctl.en4   = !r_v4 || !i_stall;
        ctl.en3   = !r_v3 || ctl.en4;
        ctl.en2   = !r_v2 || ctl.en3;
        ctl.en1   = !r_v1 || ctl.en2;
        ctl.take1 = ctl.en1 && i_valid;
        ctl.take3 = ctl.en3 && r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ctl.en1) r_v1 <= i_valid;
            if (ctl.en2) r_v2 <= r_v1;
            if (ctl.en3) r_v3 <= r_v2;
            if (ctl.en4) r_v4 <= r_v3;
        end
    end

    pisc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pisc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cfg          (cfg),
        .i_error_sample (i_error_sample),
        .o_term_p       (term_p),
        .o_term_i       (term_i),
        .o_term_d       (term_d),
        .o_sep_ok       (sep_ok)
    );

    pisc_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_cfg         (cfg),
        .i_term_p      (term_p),
        .i_term_i      (term_i),
        .i_term_d      (term_d),
        .i_sep_ok      (sep_ok),
        .o_drive_value (o_drive_value)
    );

    assign o_stall = !ctl.en1;
    assign o_valid = r_v4;

endmodule

>>> hw/rtl/pisc_cfg_regs.sv
// Configuration register file of the PID block.
module pisc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pisc_pkg::t_cfg                o_cfg
);
    import pisc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p  <= RST_GAIN_P;
            r_cfg.gain_i  <= RST_GAIN_I;
            r_cfg.gain_d  <= RST_GAIN_D;
            r_cfg.out_lim <= RST_OUT_LIM;
            r_cfg.int_lim <= RST_INT_LIM;
            r_cfg.sep_lim <= RST_SEP_LIM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:  r_cfg.gain_p  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:  r_cfg.gain_i  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:  r_cfg.gain_d  <= i_cfg_data[GAIN_W-1:0];
                CFG_OUT_LIM: r_cfg.out_lim <= i_cfg_data[LIM_W-1:0];
                CFG_INT_LIM: r_cfg.int_lim <= i_cfg_data[LIM_W-1:0];
                CFG_SEP_LIM: r_cfg.sep_lim <= i_cfg_data[SEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/pisc_front.sv
// Input register, error difference, separation test and the three gain products.
module pisc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pisc_pkg::t_pipe_ctl                 i_ctl,
    input  pisc_pkg::t_cfg                      i_cfg,
    input  logic signed [pisc_pkg::ERR_W-1:0]   i_error_sample,
    output logic signed [pisc_pkg::TERM_W-1:0]  o_term_p,
    output logic signed [pisc_pkg::TERM_W-1:0]  o_term_i,
    output logic signed [pisc_pkg::TERM_W-1:0]  o_term_d,
    output logic                                o_sep_ok
);
    import pisc_pkg::*;

    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_sep_ok;
    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0]        err_mag;
    logic signed [DIFF_W-1:0] err_x;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [TERM_W-1:0] r_term_p;
    logic signed [TERM_W-1:0] r_term_i;
    logic signed [TERM_W-1:0] r_term_d;
    logic                     r_sep_ok2;
    logic signed [DIFF_W-1:0] in_x;

    assign in_x    = DIFF_W'(i_error_sample);
    assign n_diff  = in_x - DIFF_W'(r_prev_err);
    assign err_mag = in_x[DIFF_W-1] ? DIFF_W'(-in_x) : DIFF_W'(in_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (i_ctl.take1) begin
            r_prev_err <= i_error_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_err    <= i_error_sample;
            r_diff   <= n_diff;
            r_sep_ok <= (err_mag <= {{(DIFF_W-SEP_W){1'b0}}, i_cfg.sep_lim});
        end
    end

    // Signed error or error difference times unsigned gain; the arithmetic shift gives floor division.
    assign err_x  = DIFF_W'(r_err);
    assign prod_p = PROD_W'(err_x)  * PROD_W'($signed({1'b0, i_cfg.gain_p}));
    assign prod_i = PROD_W'(err_x)  * PROD_W'($signed({1'b0, i_cfg.gain_i}));
    assign prod_d = PROD_W'(r_diff) * PROD_W'($signed({1'b0, i_cfg.gain_d}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_term_p  <= prod_p[PROD_W-1:FRAC_SHIFT];
            r_term_i  <= prod_i[PROD_W-1:FRAC_SHIFT];
            r_term_d  <= prod_d[PROD_W-1:FRAC_SHIFT];
            r_sep_ok2 <= r_sep_ok;
        end
    end

    assign o_term_p = r_term_p;
    assign o_term_i = r_term_i;
    assign o_term_d = r_term_d;
    assign o_sep_ok = r_sep_ok2;

endmodule

>>> hw/rtl/pisc_accum.sv
// Integrator update with clamp, output sum and output saturation register.
module pisc_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pisc_pkg::t_pipe_ctl                 i_ctl,
    input  pisc_pkg::t_cfg                      i_cfg,
    input  logic signed [pisc_pkg::TERM_W-1:0]  i_term_p,
    input  logic signed [pisc_pkg::TERM_W-1:0]  i_term_i,
    input  logic signed [pisc_pkg::TERM_W-1:0]  i_term_d,
    input  logic                                i_sep_ok,
    output logic signed [pisc_pkg::DRV_W-1:0]   o_drive_value
);
    import pisc_pkg::*;

    logic signed [DRV_W-1:0] r_integ;
    logic signed [DRV_W-1:0] n_integ;
    logic signed [SUM_W-1:0] integ_acc;
    logic signed [SUM_W-1:0] r_pd;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DRV_W-1:0] r_drive;

    assign integ_acc = i_sep_ok ? SUM_W'(r_integ) + SUM_W'(i_term_i) : SUM_W'(r_integ);
    assign n_integ   = clamp_sym(integ_acc, i_cfg.int_lim);

    // The integrator holds the value of the transaction in stage three until it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctl.take3) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_pd <= SUM_W'(i_term_p) + SUM_W'(i_term_d);
        end
    end

    assign n_sum = r_pd + SUM_W'(r_integ);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_drive <= clamp_sym(n_sum, i_cfg.out_lim);
        end
    end

    assign o_drive_value = r_drive;

endmodule

>>> hw/rtl/pisc_checker.sv
// Port-level checker for the PID block and its bind to the top level.
module pisc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [pisc_pkg::DRV_W-1:0] o_drive_value
);
    import pisc_pkg::*;

    // A result that is held back keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive_value))
        else $error("stalled result changed");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // Back pressure on the input only comes from a held result.
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back pressure");

    // With no result waiting, the block always takes input.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output is empty");

endmodule

bind pid_integral_separation_clamp pisc_checker u_pisc_checker (.*);

>>> test/testbench.sv
// Self-checking testbench of the PID controller with integral separation and clamps.
module testbench;
    import pisc_pkg::*;

    // Cycles from input acceptance to a valid result.
    localparam int PIPE_LATENCY = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_PHASE = 200;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [ERR_W-1:0] i_error_sample = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [DRV_W-1:0] o_drive_value;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // Shadow copy of the controller: its registers and its two state words.
    t_cfg                    ctl_regs;
    logic signed [DRV_W-1:0] integ_acc;
    logic signed [ERR_W-1:0] prev_sample;

    // Drive values predicted for accepted transactions, oldest first.
    logic signed [DRV_W-1:0] drive_q[$];

    int gap_pct = 0;
    int stall_pct = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    pid_integral_separation_clamp DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_error_sample (i_error_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive_value  (o_drive_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The output side stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: a run that hangs is reported as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every transaction taken from the output is compared with the oldest prediction.
    always @(posedge i_clk) begin
        logic signed [DRV_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected drive_value, expected none, actual %0d",
                         $time, o_drive_value);
            end else begin
                want = drive_q.pop_front();
                if (o_drive_value !== want) begin
                    fail_cnt++;
                    $display("%0t: drive_value expected %0d, actual %0d",
                             $time, want, o_drive_value);
                end
            end
        end
    end

    // Gain times a signed integer at full width, in Q16.16; the arithmetic
    // shift floors, so negative products round toward minus infinity.
    function automatic longint scale_by_gain(input logic [GAIN_W-1:0] gain, input longint x);
        longint prod;
        prod = x * longint'({32'd0, gain});
        return prod >>> FRAC_SHIFT;
    endfunction

    function automatic longint sat_to_limit(input longint v, input logic [LIM_W-1:0] lim);
        longint bound;
        bound = longint'({33'd0, lim});
        if (v > bound) begin
            return bound;
        end else if (v < -bound) begin
            return -bound;
        end
        return v;
    endfunction

    // One control tick of the controller; updates the shadow state.
    function automatic logic signed [DRV_W-1:0] predict_drive(input logic signed [ERR_W-1:0] err);
        longint e;
        longint mag;
        longint acc;
        longint total;
        e = err;
        mag = (e < 0) ? -e : e;
        acc = longint'(integ_acc);
        // Integral separation: large errors leave the integrator untouched,
        // but the clamp still applies in case the limit was lowered.
        if (mag <= longint'(ctl_regs.sep_lim)) begin
            acc += scale_by_gain(ctl_regs.gain_i, e);
        end
        integ_acc = DRV_W'(sat_to_limit(acc, ctl_regs.int_lim));
        total = scale_by_gain(ctl_regs.gain_p, e) + longint'(integ_acc)
              + scale_by_gain(ctl_regs.gain_d, e - longint'(prev_sample));
        prev_sample = err;
        return DRV_W'(sat_to_limit(total, ctl_regs.out_lim));
    endfunction

    // Sends one transaction after a random gap. Valid is left high on return,
    // so the caller must either send again or pause without advancing time.
    task automatic send_error(input logic signed [ERR_W-1:0] err);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_error_sample <= err;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        drive_q.push_back(predict_drive(err));
    endtask

    // Stops the input, waits for every predicted result, then lets the
    // pipeline settle so that a register write finds the block idle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (drive_q.size() != 0);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; end_writes lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:  ctl_regs.gain_p  = data[GAIN_W-1:0];
            CFG_GAIN_I:  ctl_regs.gain_i  = data[GAIN_W-1:0];
            CFG_GAIN_D:  ctl_regs.gain_d  = data[GAIN_W-1:0];
            CFG_OUT_LIM: ctl_regs.out_lim = data[LIM_W-1:0];
            CFG_INT_LIM: ctl_regs.int_lim = data[LIM_W-1:0];
            CFG_SEP_LIM: ctl_regs.sep_lim = data[SEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2, 3: return $urandom;
            default: return $urandom_range(0, 1 << 26);
        endcase
    endfunction

    // Limits carry random junk in bit 31, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom;
            default: v = $urandom_range(1, 1 << 25);
        endcase
        v[31] = $urandom_range(0, 1);
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_separation();
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[SEP_W-1:0] = '0;
            1: v[SEP_W-1:0] = '1;
            2: ;
            default: v[SEP_W-1:0] = $urandom_range(1, 2000);
        endcase
        return v;
    endfunction

    task automatic write_random_config();
        write_reg(CFG_GAIN_P, pick_gain());
        write_reg(CFG_GAIN_I, pick_gain());
        write_reg(CFG_GAIN_D, pick_gain());
        write_reg(CFG_OUT_LIM, pick_limit());
        write_reg(CFG_INT_LIM, pick_limit());
        write_reg(CFG_SEP_LIM, pick_separation());
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI, $urandom);
        end
        end_writes();
    endtask

    // Most errors fall inside the separation band so the integrator moves;
    // the rest sit on its edge or anywhere in the full range.
    function automatic logic signed [ERR_W-1:0] pick_error();
        int sep;
        int v;
        sep = ctl_regs.sep_lim;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2, 3: v = ($urandom_range(0, 1) ? 1 : -1) * (sep + $urandom_range(0, 1));
            default: v = int'($urandom_range(0, 2 * sep)) - sep;
        endcase
        return ERR_W'(v);
    endfunction

    // Reset values of the registers, with edge and extreme errors.
    task automatic test_reset_defaults();
        logic signed [ERR_W-1:0] errs[9];
        errs = '{16'sd0, 16'sd1, -16'sd1, 16'sd100, -16'sd100, 16'sd101, -16'sd101,
                 16'sd32767, -16'sd32768};
        foreach (errs[k]) send_error(errs[k]);
        wait_drained();
    endtask

    // Maximum gains and limits; over-wide data and spare indexes must be handled.
    task automatic test_register_extremes();
        write_reg(CFG_IDX_SPARE_LO, $urandom);
        write_reg(CFG_IDX_SPARE_HI, $urandom);
        write_reg(CFG_GAIN_P, ALL_ONES);
        write_reg(CFG_GAIN_I, ALL_ONES);
        write_reg(CFG_GAIN_D, ALL_ONES);
        write_reg(CFG_OUT_LIM, ALL_ONES);
        write_reg(CFG_INT_LIM, ALL_ONES);
        write_reg(CFG_SEP_LIM, ALL_ONES);
        end_writes();
        // Alternating extremes give the widest error difference and sums.
        send_error(16'sd32767);
        send_error(-16'sd32768);
        send_error(16'sd32767);
        send_error(-16'sd32768);
        send_error(16'sd0);
        wait_drained();
    endtask

    // A zero limit pins the integrator and the output to zero.
    task automatic test_zero_limits();
        write_reg(CFG_OUT_LIM, 32'h8000_0000);
        write_reg(CFG_INT_LIM, 32'h8000_0000);
        write_reg(CFG_GAIN_P, $urandom);
        end_writes();
        send_error(16'sd5);
        send_error(-16'sd7);
        send_error(16'sd32767);
        wait_drained();
    endtask

    // With only integral gain at one, the output shows exactly when the
    // integrator moves at and just past the separation limit.
    task automatic test_separation_edge();
        int sep;
        sep = $urandom_range(1, 32766);
        write_reg(CFG_GAIN_P, '0);
        write_reg(CFG_GAIN_D, '0);
        write_reg(CFG_GAIN_I, 32'h0100_0000);
        write_reg(CFG_OUT_LIM, 32'h7FFF_FFFF);
        write_reg(CFG_INT_LIM, 32'h7FFF_FFFF);
        write_reg(CFG_SEP_LIM, sep);
        end_writes();
        send_error(ERR_W'(sep));
        send_error(ERR_W'(-sep));
        send_error(ERR_W'(sep + 1));
        send_error(ERR_W'(-sep - 1));
        wait_drained();
        // The most negative error never integrates: its magnitude exceeds 15 bits.
        write_reg(CFG_SEP_LIM, 32'h0000_7FFF);
        end_writes();
        send_error(16'sd32767);
        send_error(-16'sd32768);
        wait_drained();
    endtask

    // Random configurations and errors under each idling pattern. Halfway
    // through each phase the input pauses until all results are back.
    task automatic test_random_traffic();
        int gaps[4];
        int stalls[4];
        gaps = '{0, 54, 0, 15};
        stalls = '{0, 0, 54, 15};
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = gaps[ph];
            stall_pct = stalls[ph];
            write_random_config();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    if ($urandom_range(0, 1)) begin
                        write_random_config();
                    end
                end
                send_error(pick_error());
            end
            wait_drained();
        end
    endtask

    initial begin
        ctl_regs.gain_p  = RST_GAIN_P;
        ctl_regs.gain_i  = RST_GAIN_I;
        ctl_regs.gain_d  = RST_GAIN_D;
        ctl_regs.out_lim = RST_OUT_LIM;
        ctl_regs.int_lim = RST_INT_LIM;
        ctl_regs.sep_lim = RST_SEP_LIM;
        integ_acc = '0;
        prev_sample = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 15;
        stall_pct = 15;
        test_reset_defaults();
        test_register_extremes();
        test_zero_limits();
        test_separation_edge();
        test_random_traffic();

        if (drive_q.size() != 0) begin
            fail_cnt++;
            $display("%0t: %0d drive values expected but never seen", $time, drive_q.size());
        end
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
